### sv/rrbm_pkg.sv
// Shared types and constants for the bank mapper with battery clock.
`timescale 1ns / 1ps
`default_nettype none

package rrbm_pkg;

    localparam int RAM_BYTES     = 65536;
    localparam int SECOND_CYCLES = 4194304;

    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int SUB_W      = $clog2(SECOND_CYCLES);
    localparam int CYC_W      = 10;
    localparam int CFG_DATA_W = 9;

    // Transaction kinds; code 3 is unused
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TGT_SYSTEM = 2'd0,
        TGT_ROM    = 2'd1,
        TGT_DATA   = 2'd2,
        TGT_NONE   = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        CFG_EXTENDED  = 2'd0,
        CFG_CLOCK     = 2'd1,
        CFG_ROM_COUNT = 2'd2,
        CFG_RAM_COUNT = 2'd3
    } cfg_idx_t;

    // 8 KiB bus areas, address[15:13]
    localparam logic [2:0] AREA_0000 = 3'd0;
    localparam logic [2:0] AREA_2000 = 3'd1;
    localparam logic [2:0] AREA_4000 = 3'd2;
    localparam logic [2:0] AREA_6000 = 3'd3;
    localparam logic [2:0] AREA_A000 = 3'd5;

    // Clock register select codes
    localparam logic [2:0] RTC_SEC     = 3'd0;
    localparam logic [2:0] RTC_MIN     = 3'd1;
    localparam logic [2:0] RTC_HOUR    = 3'd2;
    localparam logic [2:0] RTC_DAY_LO  = 3'd3;
    localparam logic [2:0] RTC_DAY_HI  = 3'd4;

    typedef struct packed {
        logic             tick;
        logic [CYC_W-1:0] cycles;
        logic             wr;
        logic [7:0]       data;
        logic             latch;
        logic [2:0]       sel;
    } rtc_cmd_t;

endpackage

`default_nettype wire

### sv/rrbm_rtc.sv
// Battery clock counters, latch copy and clock register read mux.
`timescale 1ns / 1ps
`default_nettype none

module rrbm_rtc (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rrbm_pkg::rtc_cmd_t cmd,
    output logic [7:0]             rd_data
);
    import rrbm_pkg::*;

    localparam int ACC_W = SUB_W + 1;
    localparam logic [ACC_W-1:0] SEC_LIMIT = ACC_W'(SECOND_CYCLES);

    logic [7:0]       sec_reg, min_reg, hr_reg;
    logic [7:0]       sec_next, min_next, hr_next;
    logic [8:0]       days_reg, days_next;
    logic             halt_reg, halt_next;
    logic             carry_reg, carry_next;
    logic [SUB_W-1:0] sub_reg, sub_next;

    logic [5:0] lat_sec_reg, lat_min_reg;
    logic [4:0] lat_hr_reg;
    logic [7:0] lat_days_reg;
    logic [2:0] lat_ctrl_reg;   // {carry, halt, day bit 8}

    logic [ACC_W-1:0] acc, acc_left;
    logic             wrap;
    logic [7:0]       sec_inc, min_inc, hr_inc;

    assign acc      = {1'b0, sub_reg} + ACC_W'(cmd.cycles);
    assign wrap     = (acc >= SEC_LIMIT);
    assign acc_left = wrap ? (acc - SEC_LIMIT) : acc;
    assign sec_inc  = sec_reg + 8'd1;
    assign min_inc  = min_reg + 8'd1;
    assign hr_inc   = hr_reg + 8'd1;

    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        days_next  = days_reg;
        halt_next  = halt_reg;
        carry_next = carry_reg;
        sub_next   = sub_reg;
        if (cmd.tick && !halt_reg)
        begin
            sub_next = acc_left[SUB_W-1:0];
            if (wrap)
            begin
                // ripple one second through the counters
                sec_next = (sec_inc == 8'd60) ? 8'd0 : sec_inc;
                if (sec_inc == 8'd60)
                begin
                    min_next = (min_inc == 8'd60) ? 8'd0 : min_inc;
                    if (min_inc == 8'd60)
                    begin
                        hr_next = (hr_inc == 8'd24) ? 8'd0 : hr_inc;
                        if (hr_inc == 8'd24)
                        begin
                            if (days_reg == 9'h1FF)
                            begin
                                days_next  = 9'd0;
                                carry_next = 1'b1;
                            end
                            else
                            begin
                                days_next = days_reg + 9'd1;
                            end
                        end
                    end
                end
            end
        end
        if (cmd.wr)
        begin
            case (cmd.sel)
                RTC_SEC:
                begin
                    sec_next = cmd.data;
                    sub_next = '0;
                end
                RTC_MIN:    min_next  = cmd.data;
                RTC_HOUR:   hr_next   = cmd.data;
                RTC_DAY_LO: days_next = {days_reg[8], cmd.data};
                RTC_DAY_HI:
                begin
                    days_next  = {cmd.data[0], days_reg[7:0]};
                    halt_next  = cmd.data[6];
                    carry_next = cmd.data[7];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg      <= '0;
            min_reg      <= '0;
            hr_reg       <= '0;
            days_reg     <= '0;
            halt_reg     <= 1'b0;
            carry_reg    <= 1'b0;
            sub_reg      <= '0;
            lat_sec_reg  <= '0;
            lat_min_reg  <= '0;
            lat_hr_reg   <= '0;
            lat_days_reg <= '0;
            lat_ctrl_reg <= '0;
        end
        else
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hr_reg    <= hr_next;
            days_reg  <= days_next;
            halt_reg  <= halt_next;
            carry_reg <= carry_next;
            sub_reg   <= sub_next;
            if (cmd.latch)
            begin
                lat_sec_reg  <= sec_reg[5:0];
                lat_min_reg  <= min_reg[5:0];
                lat_hr_reg   <= hr_reg[4:0];
                lat_days_reg <= days_reg[7:0];
                lat_ctrl_reg <= {carry_reg, halt_reg, days_reg[8]};
            end
        end
    end

    always_comb
    begin
        case (cmd.sel)
            RTC_SEC:    rd_data = {2'b00, lat_sec_reg};
            RTC_MIN:    rd_data = {2'b00, lat_min_reg};
            RTC_HOUR:   rd_data = {3'b000, lat_hr_reg};
            RTC_DAY_LO: rd_data = lat_days_reg;
            RTC_DAY_HI: rd_data = {lat_ctrl_reg[2], lat_ctrl_reg[1], 5'b00000, lat_ctrl_reg[0]};
            default:    rd_data = 8'hFF;
        endcase
    end

endmodule

`default_nettype wire

### sv/rom_ram_bank_mapper_with_rtc_core.sv
// Top level: cartridge bank mapper with cartridge RAM and battery clock.
// Path: an accepted transaction goes to stage 1 (beside the RAM read register), then to
//   the output register, where out_stall can hold it. The RAM is single-port.
// Throughput: one transaction per cycle unless stalled; each uses at most one RAM access.
// Reset: control state and clock counters clear at once; then a clearing pass writes 0xFF to
//   all RAM_BYTES cartridge RAM entries, one per cycle, with in_stall high.
`timescale 1ns / 1ps
`default_nettype none

module rom_ram_bank_mapper_with_rtc_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [rrbm_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      kind,
    input  wire logic [15:0]                     address,
    input  wire logic [7:0]                      write_data,
    input  wire logic [rrbm_pkg::CYC_W-1:0]      tick_cycles,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           target,
    output logic [21:0]                          rom_address,
    output logic [7:0]                           read_data,
    output logic                                 ram_closed
);
    import rrbm_pkg::*;

    localparam logic [16:0]       RAM_LIMIT = 17'(RAM_BYTES);
    localparam logic [RAM_AW-1:0] CLR_LAST  = RAM_AW'(RAM_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       ext_reg;
    logic       clkp_reg;
    logic [8:0] rom_cnt_reg;
    logic [3:0] ram_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg     <= 1'b0;
            clkp_reg    <= 1'b1;
            rom_cnt_reg <= 9'd128;
            ram_cnt_reg <= 4'd4;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_EXTENDED:  ext_reg     <= cfg_data[0];
                CFG_CLOCK:     clkp_reg    <= cfg_data[0];
                CFG_ROM_COUNT: rom_cnt_reg <= cfg_data[8:0];
                CFG_RAM_COUNT: ram_cnt_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Mapper state
    // ------------------------------------------------------------------
    logic [7:0] rom_bank_reg;
    logic       bank_hi_reg;     // bit 2 of the last RAM bank write, for the bank 4-7 block
    logic [2:0] ram_off_reg;
    logic       clk_sel_reg;
    logic [2:0] crs_reg;
    logic       ram_en_reg;
    logic       clk_en_reg;

    state_t            state_reg, state_next;
    logic [RAM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic in_accept;
    logic s1_valid_reg, s1_valid_next;
    logic s1_adv;
    logic out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Decode of the offered transaction against current state
    // ------------------------------------------------------------------
    logic [2:0]  region;
    logic        hidden;
    logic [15:0] idx_raw;
    logic [16:0] idx_ext, idx_wrap;
    logic [RAM_AW-1:0] ram_idx;
    logic        wr_on;
    logic [7:0]  rom_req, rom_nz;
    logic [8:0]  rom_mask;
    logic [2:0]  ram_mask;
    logic [3:0]  ram_cnt_m1;

    target_t     dec_target;
    logic [21:0] dec_rom_addr;
    logic [7:0]  dec_rd_data;
    logic        dec_use_ram;
    logic        dec_closed;
    logic        do_ram_rd, do_ram_wr, do_rtc_wr, do_latch, do_tick;
    logic        set_enable, set_rom, set_bank;

    logic [7:0]  rtc_rd_data;
    rtc_cmd_t    rtc_cmd;

    assign region = address[15:13];
    // banks 4-7 invisible in the normal variant when the clock is fitted
    assign hidden = !ext_reg && clkp_reg && bank_hi_reg;

    // RAM index, wrapped into the store with one compare and subtract
    assign idx_raw  = {ram_off_reg, address[12:0]};
    assign idx_ext  = {1'b0, idx_raw};
    assign idx_wrap = (idx_ext >= RAM_LIMIT) ? (idx_ext - RAM_LIMIT) : idx_ext;
    assign ram_idx  = idx_wrap[RAM_AW-1:0];

    assign wr_on      = (write_data[3:0] == 4'hA);
    assign rom_req    = ext_reg ? write_data : {1'b0, write_data[6:0]};
    assign rom_nz     = (rom_req == 8'd0) ? 8'd1 : rom_req;
    assign rom_mask   = rom_cnt_reg - 9'd1;
    assign ram_cnt_m1 = ram_cnt_reg - 4'd1;
    assign ram_mask   = (ram_cnt_reg == 4'd0) ? 3'b111 : ram_cnt_m1[2:0];

    always_comb
    begin
        dec_target   = TGT_NONE;
        dec_rom_addr = '0;
        dec_rd_data  = '0;
        dec_use_ram  = 1'b0;
        dec_closed   = 1'b0;
        do_ram_rd    = 1'b0;
        do_ram_wr    = 1'b0;
        do_rtc_wr    = 1'b0;
        do_latch     = 1'b0;
        do_tick      = 1'b0;
        set_enable   = 1'b0;
        set_rom      = 1'b0;
        set_bank     = 1'b0;
        case (kind)
            KIND_READ:
            begin
                case (region) inside
                    AREA_4000, AREA_6000:
                    begin
                        dec_target   = TGT_ROM;
                        dec_rom_addr = {rom_bank_reg, address[13:0]};
                    end
                    AREA_A000:
                    begin
                        dec_target = TGT_DATA;
                        if (!clk_sel_reg)
                        begin
                            if (ram_en_reg && !hidden)
                            begin
                                dec_use_ram = 1'b1;
                                do_ram_rd   = 1'b1;
                            end
                            else
                            begin
                                dec_rd_data = 8'hFF;
                            end
                        end
                        else if (!clkp_reg || !clk_en_reg)
                        begin
                            dec_rd_data = 8'hFF;
                        end
                        else
                        begin
                            dec_rd_data = rtc_rd_data;
                        end
                    end
                    default: dec_target = TGT_SYSTEM;
                endcase
            end
            KIND_WRITE:
            begin
                case (region)
                    AREA_0000:
                    begin
                        set_enable = 1'b1;
                        dec_closed = ram_en_reg && !wr_on;
                    end
                    AREA_2000: set_rom  = 1'b1;
                    AREA_4000: set_bank = 1'b1;
                    AREA_6000: do_latch = clkp_reg;
                    AREA_A000:
                    begin
                        if (!clk_sel_reg)
                            do_ram_wr = ram_en_reg && !hidden;
                        else
                            do_rtc_wr = clkp_reg && clk_en_reg;
                    end
                    default: dec_target = TGT_SYSTEM;
                endcase
            end
            KIND_TICK: do_tick = clkp_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= 8'd1;
            bank_hi_reg  <= 1'b0;
            ram_off_reg  <= 3'd0;
            clk_sel_reg  <= 1'b0;
            crs_reg      <= 3'd0;
            ram_en_reg   <= 1'b0;
            clk_en_reg   <= 1'b0;
        end
        else if (in_accept)
        begin
            if (set_enable)
            begin
                ram_en_reg <= wr_on;
                clk_en_reg <= wr_on;
            end
            if (set_rom)
                rom_bank_reg <= rom_nz & rom_mask[7:0];
            if (set_bank)
            begin
                if (clkp_reg && write_data[3])
                begin
                    crs_reg     <= write_data[2:0];
                    clk_sel_reg <= 1'b1;
                end
                else
                begin
                    bank_hi_reg <= write_data[2];
                    clk_sel_reg <= 1'b0;
                    ram_off_reg <= write_data[2:0] & ram_mask;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Battery clock
    // ------------------------------------------------------------------
    always_comb
    begin
        rtc_cmd.tick   = in_accept && do_tick;
        rtc_cmd.cycles = tick_cycles;
        rtc_cmd.wr     = in_accept && do_rtc_wr;
        rtc_cmd.data   = write_data;
        rtc_cmd.latch  = in_accept && do_latch;
        rtc_cmd.sel    = crs_reg;
    end

    rrbm_rtc u_rtc (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rtc_cmd),
        .rd_data (rtc_rd_data)
    );

    // ------------------------------------------------------------------
    // Cartridge RAM: single port, registered read data. Each RAM access
    // happens at its accept edge, so the next transaction already sees a write.
    // ------------------------------------------------------------------
    logic [7:0]        cart_mem [RAM_BYTES];
    logic              mem_en, mem_we;
    logic [RAM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata_reg;

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = 8'hFF;
        end
        else
        begin
            mem_en    = in_accept && (do_ram_rd || do_ram_wr);
            mem_we    = do_ram_wr;
            mem_addr  = ram_idx;
            mem_wdata = write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                cart_mem[mem_addr] <= mem_wdata;
            else
                mem_rdata_reg <= cart_mem[mem_addr];
        end
    end

    // clearing pass after reset
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + RAM_AW'(1);
                if (clr_addr_reg == CLR_LAST)
                    state_next = ST_RUN;
            end
            ST_RUN: ;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: stage 1 waits for RAM read data, output register decouples
    // the consumer's stall.
    // ------------------------------------------------------------------
    target_t     s1_target_reg;
    logic [21:0] s1_rom_addr_reg;
    logic [7:0]  s1_rd_data_reg;
    logic        s1_use_ram_reg;
    logic        s1_closed_reg;

    target_t     out_target_reg;
    logic [21:0] out_rom_addr_reg;
    logic [7:0]  out_rd_data_reg;
    logic        out_closed_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_RUN) || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_target_reg   <= dec_target;
            s1_rom_addr_reg <= dec_rom_addr;
            s1_rd_data_reg  <= dec_rd_data;
            s1_use_ram_reg  <= dec_use_ram;
            s1_closed_reg   <= dec_closed;
        end
        if (s1_adv)
        begin
            out_target_reg   <= s1_target_reg;
            out_rom_addr_reg <= s1_rom_addr_reg;
            out_rd_data_reg  <= s1_use_ram_reg ? mem_rdata_reg : s1_rd_data_reg;
            out_closed_reg   <= s1_closed_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = out_target_reg;
    assign rom_address = out_rom_addr_reg;
    assign read_data   = out_rd_data_reg;
    assign ram_closed  = out_closed_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("transaction accepted during RAM clearing pass");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted transaction lost before stage 1");

    a_rom_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_target_reg != TGT_ROM) |-> (rom_address == 22'd0))
        else $error("rom_address nonzero outside ROM read");

    a_rd_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_target_reg != TGT_DATA) |-> (read_data == 8'd0))
        else $error("read_data nonzero outside data read");

    a_closed_on_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ram_closed) |-> (out_target_reg == TGT_NONE))
        else $error("ram_closed set on a non-register transaction");

endmodule

`default_nettype wire

### verif/rom_ram_bank_mapper_with_rtc_core_tb.sv
// Self-checking testbench for the cartridge bank mapper with battery clock.
`timescale 1ns / 1ps

module rom_ram_bank_mapper_with_rtc_core_tb;
    import rrbm_pkg::*;

    // Kind code 3 has no enum member in the package; the block must answer it with TGT_NONE
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Bus data values with a fixed meaning
    localparam logic [7:0] RAM_ON      = 8'h0A;   // low nibble 0xA enables RAM and clock
    localparam logic [7:0] RAM_OFF     = 8'h00;
    localparam logic [7:0] CLOCK_PICK  = 8'h08;   // bit 3 selects a clock register
    localparam logic [7:0] HALT_BIT    = 8'h40;
    localparam logic [7:0] DAY_MSB_BIT = 8'h01;

    // Ticks per clock burst; a burst of maximum-size ticks stays inside one second
    localparam int TICK_BURST  = 50;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        target_t     tgt;
        logic [21:0] rom_addr;
        logic [7:0]  rdata;
        logic        closed;
    } bus_result_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            kind;
    logic [15:0]           address;
    logic [7:0]            write_data;
    logic [CYC_W-1:0]      tick_cycles;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            target;
    logic [21:0]           rom_address;
    logic [7:0]            read_data;
    logic                  ram_closed;

    rom_ram_bank_mapper_with_rtc_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .address     (address),
        .write_data  (write_data),
        .tick_cycles (tick_cycles),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target      (target),
        .rom_address (rom_address),
        .read_data   (read_data),
        .ram_closed  (ram_closed)
    );

    // ------------------------------------------------------------------
    // Mapper state as the testbench sees it
    // ------------------------------------------------------------------
    logic       cfg_ext;
    logic       cfg_rtc;
    logic [8:0] cfg_rom_cnt;
    logic [3:0] cfg_ram_cnt;

    logic [7:0] cur_rom_bank;
    logic [7:0] cur_ram_bank;
    logic [2:0] cur_ram_off;
    logic       rtc_sel_on;
    logic [2:0] rtc_sel;
    logic       ram_en;
    logic       rtc_en;
    logic [7:0] cart_mem [RAM_BYTES];
    logic [7:0] rtc_sec, rtc_min, rtc_hour, rtc_ctl;
    logic [8:0] rtc_day;
    logic [7:0] lat_sec, lat_min, lat_hour, lat_day, lat_ctl;
    int         sub_cnt;

    bus_result_t expected_results[$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;

    // ------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------
    always #4 clk = ~clk;

    // Most of the run is the 64K-entry RAM clearing pass; the cap is set far beyond it.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver back-pressure, regenerated every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // Banks 4-7 disappear in the normal variant when the clock is fitted
    function automatic logic bank_hidden();
        return !cfg_ext && cfg_rtc && (cur_ram_bank[2:0] > 3'd3);
    endfunction

    // Bank offset times 8 KiB plus window offset; 16 bits wraps at the store size
    function automatic logic [15:0] ram_slot(logic [15:0] a);
        return {cur_ram_off, a[12:0]};
    endfunction

    // Applies one transaction to the state copy and returns what the block must answer
    function automatic bus_result_t map_access(logic [1:0] k, logic [15:0] a, logic [7:0] d,
                                               logic [CYC_W-1:0] c);
        bus_result_t r;
        logic [2:0]  area;
        logic        on;
        logic [8:0]  bank;
        logic [3:0]  cnt;
        int          acc;
        r = '{TGT_NONE, 22'd0, 8'd0, 1'b0};
        area = a[15:13];
        if (k == KIND_READ)
        begin
            if (area == AREA_4000 || area == AREA_6000)
            begin
                r.tgt = TGT_ROM;
                r.rom_addr = {cur_rom_bank, a[13:0]};
            end
            else if (area == AREA_A000)
            begin
                r.tgt = TGT_DATA;
                if (!rtc_sel_on)
                    r.rdata = (!ram_en || bank_hidden()) ? 8'hFF : cart_mem[ram_slot(a)];
                else if (!cfg_rtc || !rtc_en)
                    r.rdata = 8'hFF;
                else
                begin
                    case (rtc_sel)
                        RTC_SEC:    r.rdata = lat_sec & 8'h3F;
                        RTC_MIN:    r.rdata = lat_min & 8'h3F;
                        RTC_HOUR:   r.rdata = lat_hour & 8'h1F;
                        RTC_DAY_LO: r.rdata = lat_day;
                        RTC_DAY_HI: r.rdata = lat_ctl & 8'hC1;
                        default:    r.rdata = 8'hFF;
                    endcase
                end
            end
            else
                r.tgt = TGT_SYSTEM;
        end
        else if (k == KIND_WRITE)
        begin
            if (area == AREA_0000)
            begin
                on = (d[3:0] == RAM_ON[3:0]);
                r.closed = ram_en && !on;
                ram_en = on;
                rtc_en = on;
            end
            else if (area == AREA_2000)
            begin
                bank = cfg_ext ? {1'b0, d} : {2'b00, d[6:0]};
                if (bank == 9'd0)
                    bank = 9'd1;
                bank = bank & (cfg_rom_cnt - 9'd1);
                cur_rom_bank = bank[7:0];
            end
            else if (area == AREA_4000)
            begin
                if (cfg_rtc && d[3])
                begin
                    rtc_sel = d[2:0];
                    rtc_sel_on = 1'b1;
                end
                else
                begin
                    cnt = (cfg_ram_cnt == 4'd0) ? 4'd8 : cfg_ram_cnt;
                    cur_ram_bank = d;
                    rtc_sel_on = 1'b0;
                    cur_ram_off = d[2:0] & (cnt[2:0] - 3'd1);
                end
            end
            else if (area == AREA_6000)
            begin
                if (cfg_rtc)
                begin
                    lat_sec  = rtc_sec;
                    lat_min  = rtc_min;
                    lat_hour = rtc_hour;
                    lat_day  = rtc_day[7:0];
                    lat_ctl  = (rtc_ctl & 8'hC0) | {7'd0, rtc_day[8]};
                end
            end
            else if (area == AREA_A000)
            begin
                if (!rtc_sel_on)
                begin
                    if (ram_en && !bank_hidden())
                        cart_mem[ram_slot(a)] = d;
                end
                else if (cfg_rtc && rtc_en)
                begin
                    case (rtc_sel)
                        RTC_SEC:
                        begin
                            rtc_sec = d;
                            sub_cnt = 0;
                        end
                        RTC_MIN:    rtc_min = d;
                        RTC_HOUR:   rtc_hour = d;
                        RTC_DAY_LO: rtc_day = {rtc_day[8], d};
                        RTC_DAY_HI:
                        begin
                            rtc_day = {d[0], rtc_day[7:0]};
                            rtc_ctl = d & 8'hC1;
                        end
                        default: ;
                    endcase
                end
            end
            else
                r.tgt = TGT_SYSTEM;
        end
        else if (k == KIND_TICK)
        begin
            if (cfg_rtc && !rtc_ctl[6])
            begin
                acc = sub_cnt + c;
                while (acc >= SECOND_CYCLES)
                begin
                    acc -= SECOND_CYCLES;
                    // 8-bit counters only roll at the exact limit; larger values wrap via 255
                    rtc_sec = rtc_sec + 8'd1;
                    if (rtc_sec == 8'd60)
                    begin
                        rtc_sec = 8'd0;
                        rtc_min = rtc_min + 8'd1;
                        if (rtc_min == 8'd60)
                        begin
                            rtc_min = 8'd0;
                            rtc_hour = rtc_hour + 8'd1;
                            if (rtc_hour == 8'd24)
                            begin
                                rtc_hour = 8'd0;
                                if (rtc_day == 9'h1FF)
                                begin
                                    rtc_day = 9'd0;
                                    rtc_ctl = rtc_ctl | 8'h80;   // day overflow
                                end
                                else
                                    rtc_day = rtc_day + 9'd1;
                            end
                        end
                    end
                end
                sub_cnt = acc;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_result_t want;
        bus_result_t got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{target_t'(target), rom_address, read_data, ram_closed};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result tgt/rom/rd/cl %0d/%h/%h/%b",
                             $realtime, got.tgt, got.rom_addr, got.rdata, got.closed);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.tgt !== want.tgt || got.rom_addr !== want.rom_addr ||
                    got.rdata !== want.rdata || got.closed !== want.closed)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 $realtime, want.tgt, want.rom_addr, want.rdata, want.closed,
                                 got.tgt, got.rom_addr, got.rdata, got.closed);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Transaction helpers
    // ------------------------------------------------------------------
    task automatic set_idling(input int idle_pct, input int busy_pct);
        send_idle_pct = idle_pct;
        stall_pct     = busy_pct;
    endtask

    // Presents one transaction and records its expected result at the accepting edge.
    // in_valid is only lowered in idle cycles, so back-to-back transactions keep it high.
    task automatic send_item(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d,
                             input logic [CYC_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        address     <= a;
        write_data  <= d;
        tick_cycles <= c;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        expected_results.push_back(map_access(k, a, d, c));
    endtask

    task automatic bus_read(input logic [15:0] a);
        send_item(KIND_READ, a, 8'($urandom), CYC_W'($urandom));
    endtask

    task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
        send_item(KIND_WRITE, a, d, CYC_W'($urandom));
    endtask

    task automatic clock_tick(input logic [CYC_W-1:0] c);
        send_item(KIND_TICK, 16'($urandom), 8'($urandom), c);
    endtask

    // Stops sending and waits until every result is back, plus pipeline slack
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; only called with the block idle
    task automatic load_config(input logic ext, input logic rtc, input logic [8:0] rom_cnt,
                               input logic [3:0] ram_cnt);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_EXTENDED;
        cfg_data  <= CFG_DATA_W'(ext);
        @(posedge clk);
        cfg_index <= CFG_CLOCK;
        cfg_data  <= CFG_DATA_W'(rtc);
        @(posedge clk);
        cfg_index <= CFG_ROM_COUNT;
        cfg_data  <= rom_cnt;
        @(posedge clk);
        cfg_index <= CFG_RAM_COUNT;
        cfg_data  <= CFG_DATA_W'(ram_cnt);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_ext     = ext;
        cfg_rtc     = rtc;
        cfg_rom_cnt = rom_cnt;
        cfg_ram_cnt = ram_cnt;
    endtask

    // Latch the counters, then select and read back every clock register plus an unused code
    task automatic read_clock_regs();
        int i;
        bus_write(16'h6000, 8'($urandom));
        for (i = 0; i < 6; i++)
        begin
            bus_write(16'h4000, CLOCK_PICK | 8'(i));
            bus_read(16'hA000 | 16'($urandom_range(16'h1FFF)));
        end
    endtask

    // One random transaction, biased toward the areas that change or expose state
    task automatic random_item();
        int               pick;
        int               sub;
        logic [15:0]      a;
        logic [7:0]       d;
        logic [CYC_W-1:0] c;
        pick = $urandom_range(99);
        sub  = $urandom_range(19);
        a = 16'($urandom);
        d = 8'($urandom);
        c = CYC_W'($urandom);
        if (pick < 36)
        begin
            if (sub < 9)
                a[15:13] = AREA_A000;
            else if (sub < 16)
                a[15:14] = 2'b01;      // switchable ROM window
            send_item(KIND_READ, a, d, c);
        end
        else if (pick < 76)
        begin
            if (sub < 2)
            begin
                a[15:13] = AREA_0000;
                if ($urandom_range(3) != 0)
                    d[3:0] = RAM_ON[3:0];   // mostly keep RAM open so reads see data
            end
            else if (sub < 4)
                a[15:13] = AREA_2000;
            else if (sub < 7)
                a[15:13] = AREA_4000;
            else if (sub < 8)
                a[15:13] = AREA_6000;
            else if (sub < 17)
                a[15:13] = AREA_A000;
            send_item(KIND_WRITE, a, d, c);
        end
        else if (pick < 95)
            send_item(KIND_TICK, a, d, c);
        else
            send_item(KIND_UNUSED, a, d, c);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values, every area, every kind and the named corner cases
    task automatic test_directed();
        set_idling(0, 0);
        bus_read(16'h4000);                // reset ROM bank 1
        bus_read(16'h7FFF);
        bus_read(16'h0000);                // fixed bank is system memory
        bus_read(16'h8000);
        bus_read(16'hFFFF);
        bus_read(16'hA000);                // RAM still closed: 0xFF
        bus_write(16'h0000, RAM_ON);
        bus_write(16'hA000, 8'h5A);
        bus_write(16'hBFFF, 8'hA5);
        bus_read(16'hA000);
        bus_read(16'hBFFF);
        bus_write(16'h2000, 8'h00);        // bank 0 request maps to 1
        bus_read(16'h6000);
        bus_write(16'h3FFF, 8'hFF);        // upper bit dropped in normal variant
        bus_read(16'h7FFF);
        bus_write(16'h4000, 8'h05);        // bank 5 sits in the hidden 4-7 block
        bus_write(16'hA123, 8'h11);
        bus_read(16'hA123);
        bus_write(16'h5FFF, CLOCK_PICK | 8'h05);   // unused clock register code
        bus_write(16'hA000, 8'h22);
        bus_read(16'hA000);
        bus_write(16'h8000, 8'h00);        // writes outside cartridge space
        bus_write(16'hC000, 8'hFF);
        send_item(KIND_UNUSED, 16'hFFFF, 8'hFF, '1);
        clock_tick('1);
        clock_tick('0);
        bus_write(16'h0000, RAM_OFF);      // on -> off flags ram_closed
        bus_write(16'h1FFF, RAM_OFF);      // already off: no flag
    endtask

    // Counters loaded just short of a full rollover with day bit 8 set, tick bursts,
    // halt, and an out-of-range seconds value; each phase read back through the latch
    task automatic test_clock_rollover();
        set_idling(30, 30);
        bus_write(16'h0000, RAM_ON);
        bus_write(16'h4000, CLOCK_PICK | RTC_SEC);
        bus_write(16'hA000, 8'd59);
        bus_write(16'h4000, CLOCK_PICK | RTC_MIN);
        bus_write(16'hA000, 8'd59);
        bus_write(16'h4000, CLOCK_PICK | RTC_HOUR);
        bus_write(16'hA000, 8'd23);
        bus_write(16'h4000, CLOCK_PICK | RTC_DAY_LO);
        bus_write(16'hA000, 8'hFF);
        bus_write(16'h4000, CLOCK_PICK | RTC_DAY_HI);
        bus_write(16'hA000, DAY_MSB_BIT);
        repeat (TICK_BURST) clock_tick('1);
        read_clock_regs();

        // halted clock ignores ticks
        bus_write(16'h4000, CLOCK_PICK | RTC_DAY_HI);
        bus_write(16'hA000, HALT_BIT | DAY_MSB_BIT);
        repeat (40) clock_tick(CYC_W'($urandom));
        read_clock_regs();

        // seconds above 59 are kept and read back masked
        bus_write(16'h4000, CLOCK_PICK | RTC_SEC);
        bus_write(16'hA000, 8'd200);
        bus_write(16'h4000, CLOCK_PICK | RTC_DAY_HI);
        bus_write(16'hA000, 8'h00);
        repeat (TICK_BURST) clock_tick('1);
        read_clock_regs();
    endtask

    // Clock register left selected, then the clock is removed from the cartridge
    task automatic test_clock_removed();
        set_idling(0, 45);
        bus_write(16'h0000, RAM_ON);
        bus_write(16'h4000, CLOCK_PICK | RTC_MIN);
        wait_idle();
        load_config(1'b0, 1'b0, 9'd128, 4'd4);
        bus_read(16'hA000);
        bus_write(16'hA000, 8'h33);
        bus_read(16'hA000);
        clock_tick('1);
        bus_write(16'h6000, 8'h00);
        bus_write(16'h4000, 8'h0B);        // bit 3 now selects a RAM bank
        bus_write(16'hA456, 8'h77);
        bus_read(16'hA456);
        wait_idle();
        load_config(1'b0, 1'b1, 9'd128, 4'd4);
        bus_read(16'hA456);
    endtask

    // Random traffic over a spread of settings and idling mixes; each setting
    // also drains completely half way through
    task automatic test_config_sweep();
        int         i;
        int         n;
        logic       ext_v[8]     = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        logic       rtc_v[8]     = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        logic [8:0] rom_v[8]     = '{9'd256, 9'd2, 9'd4, 9'd256, 9'd2, 9'd64, 9'd32, 9'd128};
        logic [3:0] ram_v[8]     = '{4'd8, 4'd0, 4'd1, 4'd2, 4'd0, 4'd8, 4'd4, 4'd1};
        int         idle_v[4]    = '{0, 45, 0, 30};
        int         busy_v[4]    = '{0, 0, 45, 30};
        for (i = 0; i < 8; i++)
        begin
            wait_idle();
            load_config(ext_v[i], rtc_v[i], rom_v[i], ram_v[i]);
            set_idling(idle_v[i % 4], busy_v[i % 4]);
            for (n = 0; n < 70; n++)
            begin
                if (n == 35)
                    wait_idle();
                random_item();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_EXTENDED;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_READ;
        address     = '0;
        write_data  = '0;
        tick_cycles = '0;
        out_stall   = 1'b0;
        mismatches  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // state copy at reset
        cfg_ext      = 1'b0;
        cfg_rtc      = 1'b1;
        cfg_rom_cnt  = 9'd128;
        cfg_ram_cnt  = 4'd4;
        cur_rom_bank = 8'd1;
        cur_ram_bank = 8'd0;
        cur_ram_off  = 3'd0;
        rtc_sel_on   = 1'b0;
        rtc_sel      = 3'd0;
        ram_en       = 1'b0;
        rtc_en       = 1'b0;
        {rtc_sec, rtc_min, rtc_hour, rtc_ctl} = '0;
        rtc_day      = '0;
        {lat_sec, lat_min, lat_hour, lat_day, lat_ctl} = '0;
        sub_cnt      = 0;
        for (i = 0; i < RAM_BYTES; i++)
            cart_mem[i] = 8'hFF;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // first transaction simply waits out the RAM clearing pass on in_stall
        test_directed();
        test_clock_rollover();
        test_clock_removed();
        test_config_sweep();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
